// ----- design/tfd_pkg.sv -----
// Package for the telemetry frame deframer.
// Holds the framing byte codes, result kinds and the result record type.
// No dependencies.
`timescale 1ns / 1ps

package tfd_pkg;

    // Framing bytes
    localparam logic [7:0] SYNC_FIRST  = 8'hEB;
    localparam logic [7:0] SYNC_SECOND = 8'h90;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_LF     = 8'h0A;

    // Known ids lie strictly between these two bounds
    localparam logic [7:0] ID_LOWER = 8'h80;
    localparam logic [7:0] ID_UPPER = 8'h8A;

    // Position counter
    localparam int          POS_W      = 9;
    localparam logic [8:0]  POS_MAX    = 9'd511;
    localparam logic [8:0]  POS_HEADER = 9'd3;

    // Result kinds
    localparam logic KIND_RECORD    = 1'b0;
    localparam logic KIND_FRAME_END = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [7:0]  record_id;
        logic [31:0] record_value;
        logic        id_known;
    } t_result;

endpackage

// ----- design/tfd_byte_if.sv -----
// Byte channel into the deframer: valid, ready and one received byte.
// Depends on nothing.
`timescale 1ns / 1ps

interface tfd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- design/tfd_result_if.sv -----
// Result channel out of the deframer: valid, ready and one result item.
// Depends on nothing.
`timescale 1ns / 1ps

interface tfd_result_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  record_id;
    logic [31:0] record_value;
    logic        id_known;

    modport source (output valid, output kind, output record_id, output record_value,
                    output id_known, input ready);
    modport sink   (input valid, input kind, input record_id, input record_value,
                    input id_known, output ready);
endinterface

// ----- design/tfd_parse.sv -----
// Frame parser: state registers and the per-byte next-state logic.
// Depends on tfd_pkg.
`timescale 1ns / 1ps

module tfd_parse (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_rx_byte,
    output logic             o_emit,
    output tfd_pkg::t_result o_result
);
    import tfd_pkg::*;

    localparam logic [2:0] ST_HUNT  = 3'd0;
    localparam logic [2:0] ST_SKIP  = 3'd1;
    localparam logic [2:0] ST_SYNC2 = 3'd2;
    localparam logic [2:0] ST_LEN   = 3'd3;
    localparam logic [2:0] ST_ID    = 3'd4;
    localparam logic [2:0] ST_DATA  = 3'd5;
    localparam logic [2:0] ST_TAIL  = 3'd6;
    localparam logic [2:0] ST_LF    = 3'd7;

    logic [2:0]       r_state,  n_state;
    logic [7:0]       r_length, n_length;
    logic [POS_W-1:0] r_pos,    n_pos;
    logic [7:0]       r_id,     n_id;
    logic [1:0]       r_idx,    n_idx;
    logic [23:0]      r_acc,    n_acc;

    logic [POS_W-1:0] pos_bump;
    logic             tail_due;
    logic             id_known;

    // Saturating position increment and the end-of-records test
    assign pos_bump = (r_pos < POS_MAX) ? r_pos + 1'b1 : r_pos;
    assign tail_due = (r_length >= 8'd2) &&
                      (pos_bump >= {1'b0, r_length - 8'd2});
    assign id_known = (r_id > ID_LOWER) && (r_id < ID_UPPER);

    // Next state and result for the byte at hand
    always_comb begin
        n_state  = r_state;
        n_length = r_length;
        n_pos    = r_pos;
        n_id     = r_id;
        n_idx    = r_idx;
        n_acc    = r_acc;
        o_emit   = 1'b0;
        o_result = '{kind: KIND_RECORD, record_id: 8'd0, record_value: 32'd0,
                     id_known: 1'b0};

        case (r_state)
            ST_HUNT: begin
                if (i_rx_byte == SYNC_FIRST) begin
                    n_state = ST_SYNC2;
                end else if (i_rx_byte == SYNC_SECOND) begin
                    n_state = ST_LEN;
                end else begin
                    n_state = ST_SKIP;
                    n_pos   = '0;
                end
            end
            ST_SKIP: begin
                n_pos = '0;
                if (i_rx_byte == SYNC_FIRST) begin
                    n_state = ST_SYNC2;
                end
            end
            ST_SYNC2: begin
                if (i_rx_byte == SYNC_SECOND) begin
                    n_state = ST_LEN;
                end else begin
                    n_state = ST_SKIP;
                    n_pos   = '0;
                end
            end
            ST_LEN: begin
                n_length = i_rx_byte;
                n_pos    = POS_HEADER;
                n_state  = ST_ID;
            end
            ST_ID: begin
                n_id    = i_rx_byte;
                n_pos   = pos_bump;
                n_idx   = 2'd0;
                n_acc   = '0;
                n_state = ST_DATA;
            end
            ST_DATA: begin
                n_pos = pos_bump;
                case (r_idx)
                    2'd0: begin
                        n_acc = r_acc | {16'd0, i_rx_byte};
                        n_idx = 2'd1;
                    end
                    2'd1: begin
                        n_acc = r_acc | {8'd0, i_rx_byte, 8'd0};
                        n_idx = 2'd2;
                    end
                    2'd2: begin
                        n_acc = r_acc | {i_rx_byte, 16'd0};
                        n_idx = 2'd3;
                    end
                    default: begin
                        // Last value byte: emit the record
                        n_idx    = 2'd0;
                        n_acc    = '0;
                        n_state  = tail_due ? ST_TAIL : ST_ID;
                        o_emit   = 1'b1;
                        o_result = '{kind: KIND_RECORD, record_id: r_id,
                                     record_value: {i_rx_byte, r_acc},
                                     id_known: id_known};
                    end
                endcase
            end
            ST_TAIL: begin
                if (i_rx_byte == CHAR_CR) begin
                    n_state = ST_LF;
                end else if (i_rx_byte == CHAR_LF) begin
                    n_state = ST_HUNT;
                    n_pos   = '0;
                    o_emit  = 1'b1;
                    o_result.kind = KIND_FRAME_END;
                end else begin
                    n_state = ST_SKIP;
                    n_pos   = '0;
                end
            end
            default: begin
                // After CR only LF closes the frame
                if (i_rx_byte == CHAR_LF) begin
                    n_state = ST_HUNT;
                    n_pos   = '0;
                    o_emit  = 1'b1;
                    o_result.kind = KIND_FRAME_END;
                end else begin
                    n_state = ST_SKIP;
                    n_pos   = '0;
                end
            end
        endcase
    end

    // Advance the parse state once per processed byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_HUNT;
            r_length <= '0;
            r_pos    <= '0;
            r_id     <= '0;
            r_idx    <= '0;
            r_acc    <= '0;
        end else if (i_step) begin
            r_state  <= n_state;
            r_length <= n_length;
            r_pos    <= n_pos;
            r_id     <= n_id;
            r_idx    <= n_idx;
            r_acc    <= n_acc;
        end
    end

endmodule

// ----- design/tfd_out_reg.sv -----
// Result register: holds one finished result until the sink takes it.
// Depends on tfd_pkg.
`timescale 1ns / 1ps

module tfd_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  tfd_pkg::t_result i_result,
    input  logic             i_take,
    output logic             o_free,
    output logic             o_valid,
    output tfd_pkg::t_result o_result
);
    import tfd_pkg::*;

    logic    r_valid;
    t_result r_result;

    // Slot is free when empty or being emptied this cycle
    assign o_free   = !r_valid || i_take;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    // Track occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // Capture the result payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

// ----- design/telemetry_frame_deframer_top.sv -----
// Path: a transferred byte is held in the input register, and any result it yields is loaded into the result register.
// Throughput: one byte per cycle; the parse state updates between the
// input register and the result register, and a byte stalls only while the result
// register is full and not being taken.
// Reset: synchronous active-low i_rst_n returns the parser to header hunt and empties
// both registers.
`timescale 1ns / 1ps

module telemetry_frame_deframer_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tfd_byte_if.sink      i_rx,
    tfd_result_if.source  o_res
);
    import tfd_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;

    logic    emit;
    logic    out_free;
    logic    out_valid;
    logic    step;
    t_result step_result;
    t_result out_result;

    // A held byte proceeds unless it has a result and the result slot is full
    assign step       = r_in_valid && (!emit || out_free);
    assign i_rx.ready = !r_in_valid || step;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.ready && i_rx.valid) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    tfd_parse u_parse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_rx_byte (r_in_byte),
        .o_emit    (emit),
        .o_result  (step_result)
    );

    tfd_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (step && emit),
        .i_result (step_result),
        .i_take   (o_res.ready),
        .o_free   (out_free),
        .o_valid  (out_valid),
        .o_result (out_result)
    );

    // Drive the result channel
    assign o_res.valid        = out_valid;
    assign o_res.kind         = out_result.kind;
    assign o_res.record_id    = out_result.record_id;
    assign o_res.record_value = out_result.record_value;
    assign o_res.id_known     = out_result.id_known;

endmodule

// ----- design/tfd_checker.sv -----
// Port-level checks for the deframer result channel, bound to the top level.
// Depends on tfd_pkg and telemetry_frame_deframer_top.
`timescale 1ns / 1ps

module tfd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_kind,
    input logic [7:0]  i_record_id,
    input logic [31:0] i_record_value,
    input logic        i_id_known
);
    import tfd_pkg::*;

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // A stalled result stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // Frame-end results carry zero fields
    a_frame_end_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_kind == KIND_FRAME_END) |->
            (i_record_id == 8'd0) && (i_record_value == 32'd0) && !i_id_known)
        else $error("frame end with non-zero fields");

    // Known flag matches the id range on records
    a_id_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_kind == KIND_RECORD) |->
            (i_id_known == ((i_record_id > ID_LOWER) && (i_record_id < ID_UPPER))))
        else $error("id_known does not match record id");

endmodule

bind telemetry_frame_deframer_top tfd_checker u_tfd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_kind         (o_res.kind),
    .i_record_id    (o_res.record_id),
    .i_record_value (o_res.record_value),
    .i_id_known     (o_res.id_known)
);
